// ===== hw/rtl/smad_pkg.sv =====
// Shared types and constants of the sliding median / absolute deviation block.
// Used by smad_cell and by the top level; depends on nothing else.
`default_nettype none

package smad_pkg;

   // Configuration register: window length, 5 bits, reset 16
   localparam int CFG_W     = 5;
   localparam int CFG_RESET = 16;

   // Result cost field width and its saturation value
   localparam int COST_W   = 20;
   localparam int COST_MAX = (1 << COST_W) - 1;

   // Operation applied to every cell of the sorted row in the same cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_INSERT,
      OP_ROTATE,
      OP_REMOVE
   } cell_op_type;

endpackage : smad_pkg

`default_nettype wire

// ===== hw/rtl/smad_cell.sv =====
// One slot of the sorted window row: holds one sample and its valid bit.
// Depends on smad_pkg (cell_op_type); neighbors are wired by the top level.
`default_nettype none

module smad_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  smad_pkg::cell_op_type          op,
   input  logic signed [SAMPLE_BITS-1:0]  key,
   input  logic signed [SAMPLE_BITS-1:0]  left_value,
   input  logic                           left_valid,
   input  logic                           left_flag,
   input  logic signed [SAMPLE_BITS-1:0]  right_value,
   input  logic                           right_valid,
   output logic signed [SAMPLE_BITS-1:0]  value,
   output logic                           valid,
   output logic                           flag
);
   import smad_pkg::*;

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic                          valid_ff;
   logic                          valid_in;

   // Flag marks slots at or after the affected position of the row
   always_comb begin
      case (op)
         OP_REMOVE: flag = valid_ff && (value_ff >= key);
         default:   flag = !valid_ff || (value_ff > key);
      endcase
   end

   // Select next slot content
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         OP_INSERT: begin
            // shift up behind the new sample, or take it at the boundary
            if (flag) begin
               if (left_flag) begin
                  value_in = left_value;
                  valid_in = left_valid;
               end else begin
                  value_in = key;
                  valid_in = 1'b1;
               end
            end
         end
         OP_ROTATE: begin
            value_in = right_value;
            valid_in = right_valid;
         end
         OP_REMOVE: begin
            // close the gap left by the dropped sample
            if (flag) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold slot
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule : smad_cell

`default_nettype wire

// ===== hw/rtl/sliding_median_abs_deviation.sv =====
// Top level: sliding window median and sum of absolute deviations.
// Depends on smad_pkg and smad_cell (row of sorted window slots).
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tdata: sample
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata: median, cost
//   csr      in         csr_valid/csr_ready     csr_data: window_length
//
// An item that does not fill the window is accepted, then inserted.
// For an item that gives a result, the cost and median come from one full
// rotation of the sorted cell row past slot 0.
// Reset empties the window and sets the window length to 16.
// A finished result waits in the output register while the next transaction
// is taken; only a second result stalls until rsp_tready frees that register.
`default_nettype none

module sliding_median_abs_deviation #(
   parameter int  MAX_WINDOW  = 16,
   parameter int  SAMPLE_BITS = 16,
   localparam int ReqW        = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RspW        = ((SAMPLE_BITS + smad_pkg::COST_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ReqW-1:0]            req_tdata,   // sample
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RspW-1:0]            rsp_tdata,   // median, cost
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [smad_pkg::CFG_W-1:0] csr_data     // window_length
);
   import smad_pkg::*;

   localparam int LenW = $clog2(MAX_WINDOW + 1);
   localparam int CmpW = (CFG_W > LenW) ? CFG_W : LenW;
   localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SumW = LenW + 1;
   localparam int AccW = SAMPLE_BITS + LenW + 1;
   localparam int SatW = (AccW > COST_W + 1) ? AccW : COST_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_REMOVE
   } state_type;

   state_type                      state_ff;
   logic [CFG_W-1:0]               len_raw_ff;
   logic [LenW-1:0]                fill_ff;
   logic [AW-1:0]                  wp_ff;
   logic [AW-1:0]                  scan_ff;
   logic signed [SAMPLE_BITS-1:0]  sample_ff;
   logic signed [SAMPLE_BITS-1:0]  old_ff;
   logic signed [SAMPLE_BITS-1:0]  med_ff;
   logic signed [AccW-1:0]         acc_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]  rsp_med_ff;
   logic [COST_W-1:0]              rsp_cost_ff;

   logic signed [SAMPLE_BITS-1:0]  ring_mem [MAX_WINDOW];

   logic [LenW-1:0]                len_eff;
   logic [LenW-1:0]                mid;
   logic [LenW-1:0]                fill_in;
   logic [SumW-1:0]                old_sum;
   logic [AW-1:0]                  old_addr;
   logic                           out_free;
   logic signed [AccW-1:0]         acc_in;
   logic signed [AccW-1:0]         cost_s;
   logic signed [SatW-1:0]         cost_wide;
   logic [COST_W-1:0]              cost_sat;

   cell_op_type                    cell_op;
   logic signed [SAMPLE_BITS-1:0]  cell_key;
   logic signed [SAMPLE_BITS-1:0]  cell_value [MAX_WINDOW];
   logic                           cell_valid [MAX_WINDOW];
   logic                           cell_flag  [MAX_WINDOW];

   // Clamp the window length into 1..MAX_WINDOW
   always_comb begin
      if (len_raw_ff == '0) begin
         len_eff = LenW'(1);
      end else if (CmpW'(len_raw_ff) > CmpW'(MAX_WINDOW)) begin
         len_eff = LenW'(MAX_WINDOW);
      end else begin
         len_eff = LenW'(len_raw_ff);
      end
   end

   assign mid     = (len_eff - LenW'(1)) >> 1;
   assign fill_in = fill_ff + LenW'(1);

   // Ring slot of the oldest sample once the window is full
   always_comb begin
      old_sum = SumW'(wp_ff) + SumW'(MAX_WINDOW) - SumW'(len_eff);
      if (old_sum >= SumW'(MAX_WINDOW)) begin
         old_sum = old_sum - SumW'(MAX_WINDOW);
      end
      old_addr = AW'(old_sum);
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;

   // Accumulate the sorted window as it rotates past slot 0:
   // subtract below the median, add above it
   always_comb begin
      acc_in = acc_ff;
      if (cell_valid[0]) begin
         if (scan_ff < AW'(mid)) begin
            acc_in = acc_ff - AccW'(cell_value[0]);
         end else if (scan_ff > AW'(mid)) begin
            acc_in = acc_ff + AccW'(cell_value[0]);
         end
      end
   end

   // Even lengths have one more sample above the median than below
   always_comb begin
      if (len_eff[0]) begin
         cost_s = acc_ff;
      end else begin
         cost_s = acc_ff - AccW'(med_ff);
      end
      cost_wide = SatW'(cost_s);
      if (cost_wide > SatW'(COST_MAX)) begin
         cost_sat = COST_W'(COST_MAX);
      end else begin
         cost_sat = COST_W'(cost_wide);
      end
   end

   // Drive the cell row operation
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   cell_op = csr_valid ? OP_CLEAR : OP_HOLD;
         ST_INSERT: cell_op = OP_INSERT;
         ST_SCAN:   cell_op = OP_ROTATE;
         ST_REMOVE: cell_op = out_free ? OP_REMOVE : OP_HOLD;
         default:   cell_op = OP_HOLD;
      endcase
   end

   assign cell_key = (state_ff == ST_REMOVE) ? old_ff : sample_ff;

   // Sorted window: a row of cells, ascending from slot 0
   for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_row
      logic signed [SAMPLE_BITS-1:0] lt_value;
      logic                          lt_valid;
      logic                          lt_flag;
      logic signed [SAMPLE_BITS-1:0] rt_value;
      logic                          rt_valid;

      if (gi == 0) begin : g_first
         assign lt_value = cell_key;
         assign lt_valid = 1'b0;
         assign lt_flag  = 1'b0;
      end else begin : g_mid
         assign lt_value = cell_value[gi-1];
         assign lt_valid = cell_valid[gi-1];
         assign lt_flag  = cell_flag[gi-1];
      end

      // the last slot wraps to slot 0 on rotation and empties on removal
      if (gi == MAX_WINDOW - 1) begin : g_last
         assign rt_value = cell_value[0];
         assign rt_valid = cell_valid[0] && (cell_op == OP_ROTATE);
      end else begin : g_inner
         assign rt_value = cell_value[gi+1];
         assign rt_valid = cell_valid[gi+1];
      end

      smad_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_slot (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .key         (cell_key),
         .left_value  (lt_value),
         .left_valid  (lt_valid),
         .left_flag   (lt_flag),
         .right_value (rt_value),
         .right_valid (rt_valid),
         .value       (cell_value[gi]),
         .valid       (cell_valid[gi]),
         .flag        (cell_flag[gi])
      );
   end

   // Arrival-order ring: write on accept, read the oldest slot while inserting
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid && req_tready) begin
         ring_mem[wp_ff] <= signed'(req_tdata[SAMPLE_BITS-1:0]);
      end
      if (state_ff == ST_INSERT) begin
         old_ff <= ring_mem[old_addr];
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_raw_ff   <= CFG_W'(CFG_RESET);
         fill_ff      <= '0;
         wp_ff        <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, else drop it once the transaction completes
         if (state_ff == ST_REMOVE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  len_raw_ff <= csr_data;
                  fill_ff    <= '0;
                  wp_ff      <= '0;
               end else if (req_tvalid) begin
                  sample_ff <= signed'(req_tdata[SAMPLE_BITS-1:0]);
                  if (wp_ff == AW'(MAX_WINDOW - 1)) begin
                     wp_ff <= '0;
                  end else begin
                     wp_ff <= wp_ff + AW'(1);
                  end
                  state_ff <= ST_INSERT;
               end
            end
            ST_INSERT: begin
               fill_ff <= fill_in;
               scan_ff <= '0;
               acc_ff  <= '0;
               if (fill_in >= len_eff) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               acc_ff  <= acc_in;
               scan_ff <= scan_ff + AW'(1);
               if (cell_valid[0] && scan_ff == AW'(mid)) begin
                  med_ff <= cell_value[0];
               end
               if (scan_ff == AW'(MAX_WINDOW - 1)) begin
                  state_ff <= ST_REMOVE;
               end
            end
            ST_REMOVE: begin
               // advance only when the output register is free
               if (out_free) begin
                  fill_ff      <= fill_ff - LenW'(1);
                  rsp_med_ff   <= med_ff;
                  rsp_cost_ff  <= cost_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspW'({rsp_cost_ff, rsp_med_ff});

endmodule : sliding_median_abs_deviation

`default_nettype wire

// ===== tb/sv/tb_sliding_median_abs_deviation.sv =====
// Self-checking testbench for sliding_median_abs_deviation: stream samples, score
// window median and absolute-deviation cost against an in-bench window predictor.
// Depends on smad_pkg and the sliding_median_abs_deviation RTL.
`timescale 1ns / 100ps

module tb_sliding_median_abs_deviation;
   import smad_pkg::*;

   localparam int MAX_WINDOW    = 16;
   localparam int SAMPLE_BITS   = 16;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = MAX_WINDOW + 8;
   localparam int DIRECTED_ROWS = 16;

   typedef enum logic { ROW_LENGTH, ROW_SAMPLE } row_kind_type;

   typedef enum logic [1:0] {
      SAMPLE_FULL,
      SAMPLE_TIGHT,
      SAMPLE_EXTREME,
      SAMPLE_CLUSTER
   } sample_mode_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      int           reps;
      bit           typed;
      int           exp_median;
      int           exp_cost;
   } stim_row_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] median;
      logic [COST_W-1:0]             cost;
   } median_cost_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;   // sample
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [39:0]       rsp_tdata;   // median, cost
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_data;    // window_length

   // Window predictor state
   int           arrival_ring [MAX_WINDOW];
   int           sorted_win   [MAX_WINDOW];
   int           held_count;
   int           ring_pos;
   int           win_len_reg;

   median_cost_type median_cost_q[$];
   int              mismatch_count;
   int              samples_sent;
   int              results_seen;
   int              length_writes;
   bit              sender_idle_on;
   bit              sink_stall_on;

   // Directed rows: reset length first, then length extremes and equal samples
   stim_row_type stim_table [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE,    100, 15, 1'b0,      0,     0},
      '{ROW_SAMPLE,   -100,  1, 1'b1,    100,   200},
      '{ROW_LENGTH,      1,  1, 1'b0,      0,     0},
      '{ROW_SAMPLE,  32767,  1, 1'b1,  32767,     0},
      '{ROW_SAMPLE, -32768,  1, 1'b1, -32768,     0},
      '{ROW_LENGTH,      0,  1, 1'b0,      0,     0},
      '{ROW_SAMPLE,      0,  1, 1'b1,      0,     0},
      '{ROW_SAMPLE,     -1,  1, 1'b1,     -1,     0},
      '{ROW_LENGTH,      2,  1, 1'b0,      0,     0},
      '{ROW_SAMPLE, -32768,  1, 1'b0,      0,     0},
      '{ROW_SAMPLE,  32767,  1, 1'b1, -32768, 65535},
      '{ROW_SAMPLE,      0,  1, 1'b0,      0,     0},
      '{ROW_LENGTH,      3,  1, 1'b0,      0,     0},
      '{ROW_SAMPLE,      5,  3, 1'b1,      5,     0},
      '{ROW_SAMPLE,      5,  1, 1'b1,      5,     0},
      '{ROW_SAMPLE,     -7,  1, 1'b0,      0,     0}
   };

   int fixed_lengths [8] = '{17, 31, 16, 1, 0, 2, 15, 3};

   sliding_median_abs_deviation u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the window by one sample; return 1 with the result once it is full
   function automatic bit advance_window(input logic signed [SAMPLE_BITS-1:0] s,
                                         output median_cost_type res);
      int     eff_len;
      int     slot;
      int     oldest;
      int     mid;
      int     k;
      int     v;
      longint total;
      eff_len = (win_len_reg == 0) ? 1 :
                (win_len_reg > MAX_WINDOW) ? MAX_WINDOW : win_len_reg;
      v = int'(s);
      res = '0;
      arrival_ring[ring_pos] = v;
      ring_pos = (ring_pos + 1) % MAX_WINDOW;
      // insert in order, after any equal entries
      if (held_count < MAX_WINDOW) begin
         slot = held_count;
         while (slot > 0 && sorted_win[slot-1] > v) begin
            sorted_win[slot] = sorted_win[slot-1];
            slot--;
         end
         sorted_win[slot] = v;
         held_count++;
      end
      if (held_count < eff_len)
         return 1'b0;
      mid = sorted_win[(eff_len - 1) / 2];
      total = 0;
      for (k = 0; k < held_count; k++)
         total += (sorted_win[k] < mid) ? longint'(mid - sorted_win[k])
                                        : longint'(sorted_win[k] - mid);
      if (total > COST_MAX)
         total = COST_MAX;
      res.median = mid[SAMPLE_BITS-1:0];
      res.cost   = total[COST_W-1:0];
      // drop one entry equal to the oldest sample
      oldest = (ring_pos + MAX_WINDOW - (held_count % (MAX_WINDOW + 1))) % MAX_WINDOW;
      for (k = 0; k < held_count; k++) begin
         if (sorted_win[k] == arrival_ring[oldest]) begin
            for (slot = k; slot + 1 < held_count; slot++)
               sorted_win[slot] = sorted_win[slot+1];
            held_count--;
            break;
         end
      end
      return 1'b1;
   endfunction

   // Send one sample transaction and record what it should produce
   task automatic send_sample(input logic [15:0] s, input bit use_typed,
                              input median_cost_type typed_res);
      median_cost_type res;
      bit              produced;
      int              gap;
      gap = (sender_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      produced = advance_window(s, res);
      if (use_typed)
         median_cost_q.push_back(typed_res);
      else if (produced)
         median_cost_q.push_back(res);
      samples_sent++;
   endtask

   // Drain the block, then write the window length
   task automatic write_window_length(input logic [CFG_W-1:0] len);
      req_tvalid <= 1'b0;
      while (median_cost_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      win_len_reg = int'(len);
      held_count  = 0;
      ring_pos    = 0;
      length_writes++;
   endtask

   // Score result transactions and stall the result side in bursts
   initial begin : result_sink
      int                            stall_left;
      median_cost_type               want;
      logic signed [SAMPLE_BITS-1:0] got_median;
      logic [COST_W-1:0]             got_cost;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_median = rsp_tdata[15:0];
            got_cost   = rsp_tdata[35:16];
            if (median_cost_q.size() == 0) begin
               $error("unexpected result: median %0d, cost %0d", got_median, got_cost);
               mismatch_count++;
            end else begin
               want = median_cost_q.pop_front();
               if (got_median !== want.median) begin
                  $error("median: expected %0d, got %0d", want.median, got_median);
                  mismatch_count++;
               end
               if (got_cost !== want.cost) begin
                  $error("cost: expected %0d, got %0d", want.cost, got_cost);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(0, 5));
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run if no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int              row;
      int              k;
      int              len;
      int              n_items;
      int              base;
      int              random_items;
      int              phase;
      bit              tail;
      logic [15:0]     s;
      median_cost_type typed_res;
      sample_mode_type mode;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      reset          = 1'b1;
      mismatch_count = 0;
      samples_sent   = 0;
      results_seen   = 0;
      length_writes  = 0;
      sender_idle_on = 1'b1;
      sink_stall_on  = 1'b1;
      held_count     = 0;
      ring_pos       = 0;
      win_len_reg    = CFG_RESET;
      random_items   = 0;
      phase          = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; typed rows check their last copy by value
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (stim_table[row].kind == ROW_LENGTH) begin
            write_window_length(CFG_W'(stim_table[row].value));
         end else begin
            typed_res.median = SAMPLE_BITS'(stim_table[row].exp_median);
            typed_res.cost   = COST_W'(stim_table[row].exp_cost);
            for (k = 0; k < stim_table[row].reps; k++)
               send_sample(16'(stim_table[row].value),
                           stim_table[row].typed && (k == stim_table[row].reps - 1),
                           typed_res);
         end
      end

      // Random phases: new window length each, mixed sample distributions
      while (random_items < RANDOM_ITEMS) begin
         len  = (phase < 8) ? fixed_lengths[phase] : $urandom_range(0, 31);
         tail = (random_items >= RANDOM_ITEMS - 120);
         write_window_length(CFG_W'(len));
         sender_idle_on = !tail && ($urandom_range(0, 3) != 0);
         sink_stall_on  = !tail && ($urandom_range(0, 3) != 0);
         mode    = sample_mode_type'($urandom_range(0, 3));
         base    = $urandom_range(0, 65535);
         n_items = $urandom_range(30, 100);
         for (k = 0; k < n_items; k++) begin
            case (mode)
               SAMPLE_FULL: s = 16'($urandom_range(0, 65535));
               SAMPLE_TIGHT: s = 16'(int'($urandom_range(0, 6)) - 3);
               SAMPLE_EXTREME: begin
                  case ($urandom_range(0, 3))
                     0:       s = 16'h8000;
                     1:       s = 16'h7fff;
                     2:       s = 16'h0000;
                     default: s = 16'hffff;
                  endcase
               end
               default: s = 16'(base + int'($urandom_range(0, 400)) - 200);
            endcase
            send_sample(s, 1'b0, '0);
            random_items++;
         end
         phase++;
      end

      // Drain and let the block settle
      req_tvalid <= 1'b0;
      while (median_cost_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d samples over %0d window length settings, scored %0d results",
               samples_sent, length_writes, results_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
